>>> design/rsl_pkg.sv
`default_nettype none
package rsl_pkg;

  localparam int MAX_STOPS  = 1024;
  localparam int COORD_BITS = 24;
  localparam int MIN_VIS_W  = 16;
  localparam int IDX_W      = $clog2(MAX_STOPS);
  localparam int CNT_W      = $clog2(MAX_STOPS + 1);
  localparam int SUM_W      = ((COORD_BITS > MIN_VIS_W) ? COORD_BITS : MIN_VIS_W) + 1;
  localparam int ENTRY_W    = 2 * COORD_BITS;

  localparam logic [MIN_VIS_W-1:0] MIN_VIS_RESET = MIN_VIS_W'(24);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SCMP,
    ST_WALK,
    ST_WCMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]            command;
    logic [COORD_BITS-1:0] stop_top;
    logic [COORD_BITS-1:0] stop_height;
    logic [COORD_BITS-1:0] view_top;
  } rsl_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] stop_index;
    logic             has_stop;
  } rsl_out_t;

endpackage
`default_nettype wire

>>> design/reading_stop_lookup.sv
`default_nettype none
// Clear, append and unused commands finish in ST_IDLE (append writes one memory entry).
// Query: each search probe passes ST_SRCH (read) and ST_SCMP (compare), up to
// ceil(log2(count+1)) probes; each stop stepped past in the walk passes ST_WALK
// and ST_WCMP; the result is then loaded in ST_DONE (directly on an empty table).
// The next transaction is accepted in the cycle after the result load.
// Reset clears count, FSM and output valid, sets min_visible to 24; memory is not cleared.
module reading_stop_lookup (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [15:0]      cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire rsl_pkg::rsl_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output rsl_pkg::rsl_out_t     out_data_o
);
  import rsl_pkg::*;

  // Control state
  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [MIN_VIS_W-1:0]   min_vis_q;

  // Query working registers: search window [lo, hi), probe and result
  logic [CNT_W-1:0]       lo_q, lo_d;
  logic [CNT_W-1:0]       hi_q, hi_d;
  logic [CNT_W-1:0]       mid_q, mid_d;
  logic [CNT_W-1:0]       res_q, res_d;
  logic                   has_q, has_d;
  logic [COORD_BITS-1:0]  view_q, view_d;

  // Output register, parts the result side from the input side
  logic                   out_valid_q, out_valid_d;
  rsl_out_t               out_data_q, out_data_d;

  // Stop memory: {top, height} per entry
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [COORD_BITS-1:0]  rd_top, rd_height;

  logic                   in_acc;
  logic [CNT_W-1:0]       mid_c;
  logic [SUM_W-1:0]       bottom, view_ext, want, view_want;
  logic                   out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ram_we = in_acc && (in_data_i.command == CMD_APPEND) &&
                  (in_data_i.stop_height != '0) && (count_q < CNT_W'(MAX_STOPS));

  rsl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_STOPS)
  ) u_stop_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({in_data_i.stop_top, in_data_i.stop_height}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_top    = ram_rdata[ENTRY_W-1:COORD_BITS];
  assign rd_height = ram_rdata[COORD_BITS-1:0];

  // Bottom edge and visibility threshold, formed without overflow
  assign bottom    = SUM_W'(rd_top) + SUM_W'(rd_height);
  assign view_ext  = SUM_W'(view_q);
  assign want      = (SUM_W'(rd_height) < SUM_W'(min_vis_q)) ? SUM_W'(rd_height)
                                                             : SUM_W'(min_vis_q);
  assign view_want = view_ext + want;

  assign mid_c    = lo_q + ((hi_q - lo_q) >> 1);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      min_vis_q   <= MIN_VIS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        min_vis_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    res_q      <= res_d;
    has_q      <= has_d;
    view_q     <= view_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    res_d       = res_q;
    has_d       = has_q;
    view_d      = view_q;
    ram_raddr   = mid_q[IDX_W-1:0];
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.command)
            CMD_CLEAR: begin
              count_d = '0;
            end
            CMD_APPEND: begin
              if (ram_we) begin
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_QUERY: begin
              view_d = in_data_i.view_top;
              lo_d   = '0;
              hi_d   = count_q;
              if (count_q == '0) begin
                has_d   = 1'b0;
                res_d   = '0;
                state_d = ST_DONE;
              end else begin
                has_d   = 1'b1;
                state_d = ST_SRCH;
              end
            end
            default: begin
              // unused command: no effect, no result
            end
          endcase
        end
      end
      ST_SRCH: begin
        if (lo_q < hi_q) begin
          ram_raddr = mid_c[IDX_W-1:0];
          mid_d     = mid_c;
          state_d   = ST_SCMP;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_SCMP: begin
        if (bottom <= view_ext) begin
          lo_d = mid_q + CNT_W'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_SRCH;
      end
      ST_WALK: begin
        if (lo_q < count_q) begin
          ram_raddr = lo_q[IDX_W-1:0];
          state_d   = ST_WCMP;
        end else begin
          // every stop passed: last index
          res_d   = count_q - CNT_W'(1);
          state_d = ST_DONE;
        end
      end
      ST_WCMP: begin
        if (bottom >= view_want) begin
          res_d   = lo_q;
          state_d = ST_DONE;
        end else begin
          lo_d    = lo_q + CNT_W'(1);
          state_d = ST_WALK;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_data_d.stop_index = res_q[IDX_W-1:0];
          out_data_d.has_stop   = has_q;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_STOPS))
    else $error("stop count beyond table size");

  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCMP) |-> (lo_q <= mid_q && mid_q < hi_q && hi_q <= count_q))
    else $error("search probe outside window");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE))
    else $error("stop memory written during a query");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending result lost or overwritten");
`endif

endmodule
`default_nettype wire

>>> design/rsl_ram.sv
`default_nettype none
module rsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> tb/sv/stop_lookup_check_pkg.sv
`timescale 1ns / 100ps
package stop_lookup_check_pkg;
  import rsl_pkg::*;

  localparam int unsigned COORD_MAX = (1 << COORD_BITS) - 1;

  // Mirror of the stop table plus the queue of answers still owed by the block.
  class stop_lookup_board;
    logic [COORD_BITS-1:0] top_mem    [MAX_STOPS];
    logic [COORD_BITS-1:0] height_mem [MAX_STOPS];
    int unsigned           stop_count;
    logic [MIN_VIS_W-1:0]  min_visible;
    rsl_out_t              expected_q [$];
    int unsigned           mismatches;

    function new();
      stop_count  = 0;
      min_visible = MIN_VIS_RESET;
      mismatches  = 0;
      foreach (top_mem[i]) begin
        top_mem[i]    = '0;
        height_mem[i] = '0;
      end
    endfunction

    function logic [SUM_W-1:0] bottom_of(int unsigned idx);
      return SUM_W'(top_mem[idx]) + SUM_W'(height_mem[idx]);
    endfunction

    // Lower bound on bottom edges, then step past stops that show too little.
    function logic [IDX_W-1:0] current_stop(logic [COORD_BITS-1:0] view);
      int unsigned           lo;
      int unsigned           hi;
      int unsigned           mid;
      logic [COORD_BITS-1:0] want;
      lo = 0;
      hi = stop_count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (bottom_of(mid) <= SUM_W'(view)) lo = mid + 1;
        else hi = mid;
      end
      while (lo < stop_count) begin
        want = height_mem[lo];
        if (COORD_BITS'(min_visible) < want) want = COORD_BITS'(min_visible);
        if (bottom_of(lo) >= SUM_W'(view) + SUM_W'(want)) break;
        lo++;
      end
      if (lo >= stop_count) lo = stop_count - 1;
      return IDX_W'(lo);
    endfunction

    function void note_command(rsl_in_t cmd_in);
      rsl_out_t answer;
      case (cmd_in.command)
        CMD_CLEAR: stop_count = 0;
        CMD_APPEND: begin
          if (cmd_in.stop_height != '0 && stop_count < MAX_STOPS) begin
            top_mem[stop_count]    = cmd_in.stop_top;
            height_mem[stop_count] = cmd_in.stop_height;
            stop_count++;
          end
        end
        CMD_QUERY: begin
          answer.has_stop   = (stop_count != 0);
          answer.stop_index = (stop_count != 0) ? current_stop(cmd_in.view_top) : '0;
          expected_q.push_back(answer);
        end
        default: ;
      endcase
    endfunction

    function void check_answer(rsl_out_t got);
      rsl_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual stop_index %0d has_stop %0b",
                 $time, got.stop_index, got.has_stop);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.stop_index !== want.stop_index) begin
        $display("%0t: stop_index expected %0d actual %0d", $time, want.stop_index,
                 got.stop_index);
        mismatches++;
      end
      if (got.has_stop !== want.has_stop) begin
        $display("%0t: has_stop expected %0b actual %0b", $time, want.has_stop, got.has_stop);
        mismatches++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/tb_reading_stop_lookup.sv
`timescale 1ns / 100ps
module tb_reading_stop_lookup;
  import rsl_pkg::*;
  import stop_lookup_check_pkg::*;

  // Command 3 has no meaning in the block; it must be swallowed without a result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned TARGET_ITEMS      = 1650;
  localparam int unsigned FULL_TABLE_STOPS  = MAX_STOPS + 6;  // runs past full on purpose
  localparam int unsigned RX_HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES     = 8;   // covers an append still in flight
  localparam int unsigned DRAIN_TAIL        = 60;
  // Worst quiet stretch: a long receiver hold plus a query walking the whole table.
  localparam int unsigned WATCHDOG_LIMIT    = 20000;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  logic     [15:0] cfg_wdata_i;
  logic     in_valid_i;
  logic     in_stall_o;
  rsl_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  rsl_out_t out_data_o;

  reading_stop_lookup dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  stop_lookup_board board;
  int unsigned      items_sent;
  int unsigned      idle_cycles;
  int unsigned      rx_stall_pct;
  bit               quiet_mode;    // no gaps on the sender, no stalls on the receiver
  int unsigned      rx_hold_reqs;  // receiver performs one long hold per request

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Unused fields of each transaction carry random bits so every input bit toggles.
  function automatic rsl_in_t clear_item();
    rsl_in_t t;
    t.command     = CMD_CLEAR;
    t.stop_top    = COORD_BITS'($urandom);
    t.stop_height = COORD_BITS'($urandom);
    t.view_top    = COORD_BITS'($urandom);
    return t;
  endfunction

  function automatic rsl_in_t append_item(logic [COORD_BITS-1:0] top,
                                          logic [COORD_BITS-1:0] height);
    rsl_in_t t;
    t.command     = CMD_APPEND;
    t.stop_top    = top;
    t.stop_height = height;
    t.view_top    = COORD_BITS'($urandom);
    return t;
  endfunction

  function automatic rsl_in_t query_item(logic [COORD_BITS-1:0] view);
    rsl_in_t t;
    t.command     = CMD_QUERY;
    t.stop_top    = COORD_BITS'($urandom);
    t.stop_height = COORD_BITS'($urandom);
    t.view_top    = view;
    return t;
  endfunction

  // Fully random transaction: any command, unordered stops, stray clears.
  function automatic rsl_in_t noise_item();
    rsl_in_t t;
    t.command     = 2'($urandom_range(0, 3));
    t.stop_top    = COORD_BITS'($urandom);
    t.stop_height = ($urandom_range(0, 7) == 0) ? '0 : COORD_BITS'($urandom);
    t.view_top    = COORD_BITS'($urandom);
    return t;
  endfunction

  // Next stop of a well-formed document: bottom edges never go down.
  // Tops may overlap the previous stop or leave a gap after it.
  function automatic rsl_in_t next_stop(inout longint last_bottom);
    longint top;
    longint height;
    top = last_bottom + longint'($urandom_range(0, 40)) - longint'($urandom_range(0, 30));
    if (top < 0) top = 0;
    if (top > COORD_MAX) top = COORD_MAX;
    height = ($urandom_range(0, 15) == 0) ? longint'($urandom_range(1, 4000))
                                          : longint'($urandom_range(1, 60));
    if (top + height < last_bottom) height = last_bottom - top;
    last_bottom = top + height;
    return append_item(COORD_BITS'(top), COORD_BITS'(height));
  endfunction

  // View tops clustered around stop edges, where the walk decisions flip.
  function automatic logic [COORD_BITS-1:0] pick_view();
    int unsigned r;
    int unsigned idx;
    longint      v;
    r = $urandom_range(0, 99);
    if (board.stop_count == 0 || r < 8) return COORD_BITS'($urandom);
    if (r < 14) return '0;
    idx = (r < 22) ? board.stop_count - 1 : $urandom_range(0, board.stop_count - 1);
    v = longint'(board.top_mem[idx]) + longint'($urandom_range(0, board.height_mem[idx] + 40))
        - longint'($urandom_range(0, 40));
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_BITS'(v);
  endfunction

  // Offer one transaction and hold it until accepted. Valid stays high when no
  // gap follows, so the next transaction goes out back to back.
  task automatic send_item(input rsl_in_t t);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    board.note_command(t);
    if (t.command != CMD_UNUSED && !(t.command == CMD_APPEND && t.stop_height == '0))
      items_sent++;
    gap = quiet_mode ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sender stops until every owed answer is back and the block has gone idle.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_min_visible(input logic [MIN_VIS_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.min_visible = value;
  endtask

  // Clear, then a document of n stops with queries and zero-height appends
  // sprinkled in. Small documents also get random noise mixed in.
  task automatic run_document(input int unsigned n_stops);
    longint      last_bottom;
    int unsigned k;
    int unsigned r;
    int unsigned query_odds;
    last_bottom = (n_stops > 64) ? longint'($urandom_range(0, 24'h400000))
                                 : longint'($urandom_range(0, COORD_MAX - 300000));
    query_odds  = (n_stops > 64) ? 8 : 3;
    send_item(clear_item());
    for (k = 0; k < n_stops; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_item(append_item(COORD_BITS'($urandom), '0));
      else if (r < 10 && n_stops <= 64) send_item(noise_item());
      send_item(next_stop(last_bottom));
      if ($urandom_range(1, query_odds) == 1) send_item(query_item(pick_view()));
    end
    repeat ((n_stops > 64) ? 20 : $urandom_range(2, 8)) send_item(query_item(pick_view()));
  endtask

  // Hand-picked edges at the reset value of min_visible.
  task automatic run_directed();
    rsl_in_t junk;
    send_item(query_item('0));                 // empty table
    send_item(query_item(COORD_BITS'(COORD_MAX)));
    junk = '1;                                 // unused command, all bits high
    junk.command = CMD_UNUSED;
    send_item(junk);
    send_item(append_item(COORD_BITS'(COORD_MAX), '0));  // zero height, dropped
    send_item(query_item(COORD_BITS'(20)));    // still empty
    send_item(append_item(COORD_BITS'(0), COORD_BITS'(10)));
    send_item(append_item(COORD_BITS'(5), COORD_BITS'(25)));
    send_item(append_item(COORD_BITS'(30), COORD_BITS'(1)));
    send_item(append_item(COORD_BITS'(40), COORD_BITS'(100)));
    // widest stop: its bottom needs the carry bit
    send_item(append_item(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX)));
    send_item(query_item('0));
    send_item(query_item(COORD_BITS'(9)));
    send_item(query_item(COORD_BITS'(10)));
    send_item(query_item(COORD_BITS'(29)));
    send_item(query_item(COORD_BITS'(30)));
    send_item(query_item(COORD_BITS'(120)));
    send_item(query_item(COORD_BITS'(140)));
    send_item(query_item(COORD_BITS'(COORD_MAX - 1)));
    send_item(query_item(COORD_BITS'(COORD_MAX)));
    send_item(clear_item());
    send_item(query_item(COORD_BITS'(50)));    // empty again after clear
    send_item(append_item(COORD_BITS'(100), COORD_BITS'(5)));
    send_item(query_item(COORD_BITS'(COORD_MAX)));  // every stop passed
    send_item(query_item('0));
  endtask

  // Receiver: random stall runs, quiet when asked, and one long hold per request.
  initial begin
    int unsigned holds_done;
    holds_done  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_reqs != holds_done) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        out_stall_i <= 1'b1;
        repeat (1 + pick_gap()) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Every accepted result goes to the checker in arrival order.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_answer(out_data_o);
  end

  // Watchdog: any transaction on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned          phase;
    int unsigned          n_stops;
    logic [MIN_VIS_W-1:0] min_vis;
    board        = new();
    items_sent   = 0;
    rx_stall_pct = 25;
    quiet_mode   = 1'b0;
    rx_hold_reqs = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Phases: each starts idle, sets min_visible, then plays one document.
    // Phase 0 and 1 hit the register extremes, phase 2 fills the table past
    // full, every fourth phase runs with no idling on either side.
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      drain_and_settle();
      case (phase)
        0:       min_vis = '0;
        1:       min_vis = '1;
        2:       min_vis = MIN_VIS_RESET;
        3:       min_vis = MIN_VIS_W'(1);
        default: min_vis = (phase % 2 == 1) ? MIN_VIS_W'($urandom_range(0, 80))
                                            : MIN_VIS_W'($urandom_range(0, 65535));
      endcase
      write_min_visible(min_vis);
      quiet_mode   = (phase % 4 == 3);
      rx_stall_pct = quiet_mode ? 0 : $urandom_range(10, 60);

      if (phase == 1) begin
        // Receiver sits on the first answer while the sender keeps offering
        // queries back to back, so the block backs up into its input.
        run_document($urandom_range(8, 20));
        quiet_mode = 1'b1;
        rx_hold_reqs++;
        repeat (12) send_item(query_item(pick_view()));
        quiet_mode = 1'b0;
      end

      if (phase == 2) n_stops = FULL_TABLE_STOPS;
      else if ($urandom_range(0, 9) == 0) n_stops = 0;
      else n_stops = $urandom_range(1, 30);
      run_document(n_stops);
      phase++;
    end

    in_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> reading_stop_lookup.f
design/rsl_pkg.sv
design/rsl_ram.sv
design/reading_stop_lookup.sv
tb/sv/stop_lookup_check_pkg.sv
tb/sv/tb_reading_stop_lookup.sv
